// ===== src/mlss_pkg.sv =====
// ----------------------------------------------------------------------------
// mlss_pkg
// Shared types and constants for the music log stream splitter.
// ----------------------------------------------------------------------------
package mlss_pkg;

  localparam logic [1:0] REGION_HEADER   = 2'd0;
  localparam logic [1:0] REGION_COMMANDS = 2'd1;
  localparam logic [1:0] REGION_TAG      = 2'd2;
  localparam logic [1:0] REGION_EXTRA    = 2'd3;

  localparam logic [31:0] VERSION_RESET    = 32'h0000_0100;
  localparam logic [31:0] DATA_START_RESET = 32'h0000_0040;

  // header offset field positions and the minimum version that enables them
  localparam logic [31:0] TAG_OFS       = 32'h0000_0014;
  localparam logic [31:0] TAG_MIN_VER   = 32'h0000_0100;
  localparam logic [31:0] DATA_OFS      = 32'h0000_0034;
  localparam logic [31:0] DATA_MIN_VER  = 32'h0000_0150;
  localparam logic [31:0] EXTRA_OFS     = 32'h0000_00bc;
  localparam logic [31:0] EXTRA_MIN_VER = 32'h0000_0170;

  localparam logic [31:0] VERSION_OFS = 32'h0000_0008;

  // identifier "Vgm " at positions 0..3
  localparam logic [7:0] IDENT [4] = '{8'h56, 8'h67, 8'h6d, 8'h20};

  typedef struct packed {
    logic [31:0] version;
    logic [31:0] tag_start;
    logic [31:0] data_start;
    logic [31:0] extra_start;
    logic        ident_err;
  } hdr_t;

endpackage

// ===== src/mlss_hdr.sv =====
// ----------------------------------------------------------------------------
// mlss_hdr
// Header field capture: identifier check, version word, offset fields.
// ----------------------------------------------------------------------------
module mlss_hdr (
  input  logic              en,
  input  logic [31:0]       pos,
  input  logic [7:0]        b,
  input  mlss_pkg::hdr_t    hdr,
  output mlss_pkg::hdr_t    hdr_next
);

  // Offset fields sit on 4-byte boundaries, so the byte lane is pos[1:0].
  function automatic logic [31:0] capture(input logic [31:0] field,
                                          input logic [31:0] hofs,
                                          input logic [31:0] minver,
                                          input logic [31:0] p,
                                          input logic [7:0]  d,
                                          input logic [31:0] ver);
    logic [31:0] f;
    f = field;
    if (p[31:2] == hofs[31:2] && ver >= minver) begin
      case (p[1:0])
        2'd0: f = {24'd0, d};
        2'd1: f = field | {16'd0, d, 8'd0};
        2'd2: f = field | {8'd0, d, 16'd0};
        2'd3: begin
          f = field | {d, 24'd0};
          if (f != 32'd0) f = f + hofs;
        end
        default: f = field;
      endcase
    end
    return f;
  endfunction

  logic [31:0] ver_upd;

  always_comb begin
    ver_upd = hdr.version;
    if (pos[31:2] == mlss_pkg::VERSION_OFS[31:2]) begin
      case (pos[1:0])
        2'd0:    ver_upd = {24'd0, b};
        2'd1:    ver_upd = hdr.version | {16'd0, b, 8'd0};
        2'd2:    ver_upd = hdr.version | {8'd0, b, 16'd0};
        2'd3:    ver_upd = hdr.version | {b, 24'd0};
        default: ver_upd = hdr.version;
      endcase
    end
  end

  always_comb begin
    hdr_next = hdr;
    if (en) begin
      hdr_next.version = ver_upd;
      if (pos[31:2] == 30'd0 && b != mlss_pkg::IDENT[pos[1:0]]) begin
        hdr_next.ident_err = 1'b1;
      end
      hdr_next.tag_start = capture(hdr.tag_start, mlss_pkg::TAG_OFS,
                                   mlss_pkg::TAG_MIN_VER, pos, b, ver_upd);
      hdr_next.data_start = capture(hdr.data_start, mlss_pkg::DATA_OFS,
                                    mlss_pkg::DATA_MIN_VER, pos, b, ver_upd);
      hdr_next.extra_start = capture(hdr.extra_start, mlss_pkg::EXTRA_OFS,
                                     mlss_pkg::EXTRA_MIN_VER, pos, b, ver_upd);
    end
  end

endmodule

// ===== src/music_log_stream_splitter.sv =====
// ----------------------------------------------------------------------------
// music_log_stream_splitter
// Tags each byte of a sound-log file with the file region it belongs to.
// ----------------------------------------------------------------------------
//  channel | dir | signals                        | item
//  s_axis  | in  | s_tvalid s_tready s_tdata[7:0] | one file byte
//  m_axis  | out | m_tvalid m_tready m_tdata[7:0] | byte, region, ident_err
//                  m_tuser[2:0]
//
//  One byte per cycle unless stalled; results show the cycle after intake.
//  Throughput is set by the single output register: s_tready is high while
//  that register is empty or being drained in the same cycle.
//  rst is synchronous: position, header fields and region return to their
//  defaults and the output register empties.
//  A stall on m_axis holds the result and backpressures s_axis.
// ----------------------------------------------------------------------------
module music_log_stream_splitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] byte_out
  output logic [2:0] m_tuser    // [1:0] region, [2] ident_err
);

  logic [31:0]    position;
  logic [31:0]    position_next;
  logic [1:0]     region;
  logic [1:0]     region_next;
  mlss_pkg::hdr_t hdr;
  mlss_pkg::hdr_t hdr_next;
  logic           accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  mlss_hdr u_hdr (
    .en       (region == mlss_pkg::REGION_HEADER),
    .pos      (position),
    .b        (s_tdata),
    .hdr      (hdr),
    .hdr_next (hdr_next)
  );

  assign position_next = position + 32'd1;

  // data offset wins over tag, tag over extra
  always_comb begin
    region_next = region;
    if (position_next == hdr_next.data_start) begin
      region_next = mlss_pkg::REGION_COMMANDS;
    end else if (hdr_next.tag_start != 32'd0 && position_next == hdr_next.tag_start) begin
      region_next = mlss_pkg::REGION_TAG;
    end else if (hdr_next.extra_start != 32'd0 &&
                 position_next == hdr_next.extra_start) begin
      region_next = mlss_pkg::REGION_EXTRA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position            <= 32'd0;
      region              <= mlss_pkg::REGION_HEADER;
      hdr.version         <= mlss_pkg::VERSION_RESET;
      hdr.tag_start       <= 32'd0;
      hdr.data_start      <= mlss_pkg::DATA_START_RESET;
      hdr.extra_start     <= 32'd0;
      hdr.ident_err       <= 1'b0;
      m_tvalid            <= 1'b0;
    end else begin
      if (accept) begin
        position <= position_next;
        region   <= region_next;
        hdr      <= hdr_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= s_tdata;
      m_tuser <= {hdr_next.ident_err, region};
    end
  end

endmodule

// ===== src/mlss_checker.sv =====
// ----------------------------------------------------------------------------
// mlss_checker
// Port-level checks for the music log stream splitter, bound to the top.
// ----------------------------------------------------------------------------
module mlss_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser
);

  logic seen_bad;
  logic seen_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_bad <= 1'b0;
      seen_out <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      seen_out <= 1'b1;
      if (m_tuser[2]) seen_bad <= 1'b1;
    end
  end

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // identifier error is sticky
  a_bad_sticky: assert property (@(posedge clk) disable iff (rst)
    seen_bad && m_tvalid |-> m_tuser[2])
    else $error("ident_err cleared");

  // first byte of a file is always header
  a_first_header: assert property (@(posedge clk) disable iff (rst)
    !seen_out && m_tvalid |-> m_tuser[1:0] == mlss_pkg::REGION_HEADER)
    else $error("first byte not tagged header");

  // an empty output register never backpressures
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low with empty output");

endmodule

bind music_log_stream_splitter mlss_checker u_mlss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
